/* src/tpd_pkg.sv */
// Shared constants and types for the triangle plane depth unit.
// No dependencies; every other file in src imports this package.
`default_nettype none

package tpd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NUM_FIELDS      = 11;
  localparam int THR_WIDTH       = 63;
  localparam logic [THR_WIDTH-1:0] FLAT_THRESHOLD_RESET = 63'd4295;

  // Per-item control flags carried alongside the arithmetic.
  typedef struct packed {
    logic edge_on;  // |c| below threshold or c zero: return minimum z
    logic neg;      // quotient is negative
    logic ovf;      // quotient magnitude needs more than COORD_WIDTH+1 bits
  } tpd_flags_t;

endpackage

`default_nettype wire

/* src/triangle_plane_depth_at_point_unit.sv */
// Triangle plane depth at a screen point: top level with result stage and register.
// Depends on tpd_pkg, tpd_plane and tpd_div.
// Path from input beat to output beat: tpd_plane, then tpd_div, then the output register.
// Throughput: one beat per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset: valid bits clear and flat_threshold returns to 4295; no clearing pass.
`default_nettype none

module triangle_plane_depth_at_point_unit #(
  parameter int CoordWidth = tpd_pkg::COORD_WIDTH_DEF
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  // Input stream. tdata from bit 0 up: point_x, point_y, v0_x, v0_y, v0_z,
  // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, each CoordWidth bits, zero padded.
  input  wire                                      s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire [((tpd_pkg::NUM_FIELDS*CoordWidth+7)/8)*8-1:0] s_axis_tdata,
  // Output stream. tdata: depth, zero padded. tuser: edge_on, saturated.
  output logic                                     m_axis_tvalid,
  input  wire                                      m_axis_tready,
  output logic [((CoordWidth+7)/8)*8-1:0]          m_axis_tdata,
  output logic [1:0]                               m_axis_tuser,
  // Configuration write channel for flat_threshold.
  input  wire                                      cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire [tpd_pkg::THR_WIDTH-1:0]             cfg_data_i
);
  import tpd_pkg::*;

  localparam int W   = CoordWidth;
  localparam int ODW = ((W + 7) / 8) * 8;
  localparam int RW  = 3 * (W + 1) + 4;
  localparam int DW  = 2 * (W + 1) + 2;
  localparam int QB  = W + 1;

  // Threshold register; writes are always accepted.
  logic [THR_WIDTH-1:0] thr_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= FLAT_THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // One shared advance for the whole pipeline. The output register takes a new
  // beat when it is empty or its current beat leaves in this cycle.
  logic en;
  logic out_v_q;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  logic               pl_v;
  logic [RW-1:0]      pl_n2;
  logic [DW-1:0]      pl_d2;
  logic [W-1:0]       pl_mz;
  tpd_flags_t         pl_flags;

  tpd_plane #(.CoordWidth(W)) u_plane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .fields_i (s_axis_tdata[NUM_FIELDS*W-1:0]),
    .thr_i    (thr_q),
    .valid_o  (pl_v),
    .n2_o     (pl_n2),
    .d2_o     (pl_d2),
    .minz_o   (pl_mz),
    .flags_o  (pl_flags)
  );

  logic               dv_v;
  logic [QB-1:0]      dv_q;
  logic [W-1:0]       dv_mz;
  tpd_flags_t         dv_flags;

  tpd_div #(.CoordWidth(W)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (pl_v),
    .n2_i     (pl_n2),
    .d2_i     (pl_d2),
    .minz_i   (pl_mz),
    .flags_i  (pl_flags),
    .valid_o  (dv_v),
    .quot_o   (dv_q),
    .minz_o   (dv_mz),
    .flags_o  (dv_flags)
  );

  // Result stage: clamp the rounded magnitude, apply the sign, or pick the
  // minimum vertex z for an edge-on triangle.
  localparam logic [QB-1:0] NEG_LIM = QB'(1) << (W - 1);
  localparam logic [QB-1:0] POS_LIM = NEG_LIM - QB'(1);

  logic [W-1:0] depth_d;
  logic         sat_d;
  always_comb begin
    if (dv_flags.edge_on) begin
      depth_d = dv_mz;
      sat_d   = 1'b0;
    end else if (dv_flags.neg) begin
      sat_d   = dv_flags.ovf || (dv_q > NEG_LIM);
      depth_d = sat_d ? W'(-NEG_LIM) : W'(-dv_q);
    end else begin
      sat_d   = dv_flags.ovf || (dv_q > POS_LIM);
      depth_d = sat_d ? W'(POS_LIM) : W'(dv_q);
    end
  end

  logic [W-1:0] depth_q;
  logic         edge_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      depth_q <= depth_d;
      edge_q  <= dv_flags.edge_on;
      sat_q   <= sat_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = ODW'(depth_q);
  assign m_axis_tuser  = {sat_q, edge_q};

  // An edge-on result never reports a clamp.
  a_edge_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("edge-on beat flagged as saturated");

  // An empty output register must never hold back the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // A configuration write lands in the threshold register.
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (thr_q == $past(cfg_data_i)))
    else $error("threshold write lost");

endmodule

`default_nettype wire

/* src/tpd_plane.sv */
// Front of the depth pipeline: edges, plane normal, numerator, divider operands.
// Depends on tpd_pkg.
`default_nettype none

module tpd_plane #(
  parameter int CoordWidth = tpd_pkg::COORD_WIDTH_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  en_i,
  input  wire                                  valid_i,
  input  wire [tpd_pkg::NUM_FIELDS*CoordWidth-1:0] fields_i,
  input  wire [tpd_pkg::THR_WIDTH-1:0]         thr_i,
  output logic                                 valid_o,
  output logic [3*(CoordWidth+1)+3:0]          n2_o,
  output logic [2*(CoordWidth+1)+1:0]          d2_o,
  output logic [CoordWidth-1:0]                minz_o,
  output tpd_pkg::tpd_flags_t                  flags_o
);
  import tpd_pkg::*;

  localparam int W  = CoordWidth;
  localparam int E  = W + 1;
  localparam int PW = 2 * E + 1;
  localparam int L  = E + 1;
  localparam int H  = PW - L;
  localparam int NW = 3 * E + 3;
  localparam int RW = NW + 1;
  localparam int QB = W + 1;
  localparam int CW = (PW > THR_WIDTH) ? PW : THR_WIDTH;

  logic signed [W-1:0] px, py, x0, y0, z0, x1, y1, z1, x2, y2, z2;
  assign px = fields_i[0*W +: W];
  assign py = fields_i[1*W +: W];
  assign x0 = fields_i[2*W +: W];
  assign y0 = fields_i[3*W +: W];
  assign z0 = fields_i[4*W +: W];
  assign x1 = fields_i[5*W +: W];
  assign y1 = fields_i[6*W +: W];
  assign z1 = fields_i[7*W +: W];
  assign x2 = fields_i[8*W +: W];
  assign y2 = fields_i[9*W +: W];
  assign z2 = fields_i[10*W +: W];

  logic [9:0] v_q;

  // Stage 1: edge vectors, point offsets and minimum vertex z.
  logic signed [E-1:0] s1_ex1_q, s1_ey1_q, s1_ez1_q, s1_ex2_q, s1_ey2_q, s1_ez2_q;
  logic signed [E-1:0] s1_dx_q, s1_dy_q;
  logic signed [W-1:0] s1_z0_q, s1_mz_q;
  logic signed [W-1:0] mz01;
  assign mz01 = (z1 < z0) ? z1 : z0;

  // Stage 2: cross product terms.
  logic signed [2*E-1:0] s2_yz_q, s2_zy_q, s2_zx_q, s2_xz_q, s2_xy_q, s2_yx_q;
  logic signed [E-1:0] s2_dx_q, s2_dy_q;
  logic signed [W-1:0] s2_z0_q, s2_mz_q;

  // Stage 3: plane normal.
  logic signed [PW-1:0] s3_a_q, s3_b_q, s3_c_q;
  logic signed [E-1:0] s3_dx_q, s3_dy_q;
  logic signed [W-1:0] s3_z0_q, s3_mz_q;

  // Stage 4: magnitude of c and the edge-on decision.
  logic signed [PW-1:0] s4_a_q, s4_b_q, s4_c_q;
  logic [PW-1:0] s4_absc_q;
  logic s4_edge_q;
  logic signed [E-1:0] s4_dx_q, s4_dy_q;
  logic signed [W-1:0] s4_z0_q, s4_mz_q;
  logic [PW-1:0] absc_d;
  logic edge_d;
  always_comb begin
    absc_d = s3_c_q[PW-1] ? PW'(-s3_c_q) : PW'(s3_c_q);
    edge_d = (s3_c_q == '0) || (CW'(absc_d) < CW'(thr_i));
  end

  // Stage 5: partial products, each operand of the normal split in two halves.
  logic signed [L+E:0]   s5_cl_q, s5_al_q, s5_bl_q;
  logic signed [H+E-1:0] s5_ch_q, s5_ah_q, s5_bh_q;
  logic [PW-1:0] s5_absc_q;
  logic s5_edge_q, s5_cneg_q;
  logic signed [W-1:0] s5_mz_q;
  logic signed [E-1:0] z0e;
  assign z0e = E'(s4_z0_q);

  // Stage 6: recombined products.
  logic signed [NW-1:0] s6_tc_q, s6_ta_q, s6_tb_q;
  logic [PW-1:0] s6_absc_q;
  logic s6_edge_q, s6_cneg_q;
  logic signed [W-1:0] s6_mz_q;
  logic signed [NW-1:0] chx, clx, ahx, alx, bhx, blx;
  always_comb begin
    chx = NW'(s5_ch_q); clx = NW'(s5_cl_q);
    ahx = NW'(s5_ah_q); alx = NW'(s5_al_q);
    bhx = NW'(s5_bh_q); blx = NW'(s5_bl_q);
  end

  // Stage 7: numerator c*z0 - a*dx - b*dy.
  logic signed [NW-1:0] s7_num_q;
  logic [PW-1:0] s7_absc_q;
  logic s7_edge_q, s7_cneg_q;
  logic signed [W-1:0] s7_mz_q;

  // Stage 8: magnitude of the numerator and quotient sign.
  logic [NW-1:0] s8_absn_q;
  logic [PW-1:0] s8_absc_q;
  logic s8_edge_q, s8_neg_q;
  logic signed [W-1:0] s8_mz_q;

  // Stage 9: rounded dividend 2|n|+|c| and divisor 2|c|.
  logic [RW-1:0] s9_n2_q;
  logic [PW:0]   s9_d2_q;
  logic s9_edge_q, s9_neg_q;
  logic signed [W-1:0] s9_mz_q;

  // Stage 10: quotient range check.
  logic [RW-1:0] s10_n2_q;
  logic [PW:0]   s10_d2_q;
  tpd_flags_t    s10_flags_q;
  logic signed [W-1:0] s10_mz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[8:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ex1_q <= E'(x1) - E'(x0);
      s1_ey1_q <= E'(y1) - E'(y0);
      s1_ez1_q <= E'(z1) - E'(z0);
      s1_ex2_q <= E'(x2) - E'(x0);
      s1_ey2_q <= E'(y2) - E'(y0);
      s1_ez2_q <= E'(z2) - E'(z0);
      s1_dx_q  <= E'(px) - E'(x0);
      s1_dy_q  <= E'(py) - E'(y0);
      s1_z0_q  <= z0;
      s1_mz_q  <= (z2 < mz01) ? z2 : mz01;

      s2_yz_q <= s1_ey1_q * s1_ez2_q;
      s2_zy_q <= s1_ez1_q * s1_ey2_q;
      s2_zx_q <= s1_ez1_q * s1_ex2_q;
      s2_xz_q <= s1_ex1_q * s1_ez2_q;
      s2_xy_q <= s1_ex1_q * s1_ey2_q;
      s2_yx_q <= s1_ey1_q * s1_ex2_q;
      s2_dx_q <= s1_dx_q; s2_dy_q <= s1_dy_q;
      s2_z0_q <= s1_z0_q; s2_mz_q <= s1_mz_q;

      s3_a_q <= PW'(s2_yz_q) - PW'(s2_zy_q);
      s3_b_q <= PW'(s2_zx_q) - PW'(s2_xz_q);
      s3_c_q <= PW'(s2_xy_q) - PW'(s2_yx_q);
      s3_dx_q <= s2_dx_q; s3_dy_q <= s2_dy_q;
      s3_z0_q <= s2_z0_q; s3_mz_q <= s2_mz_q;

      s4_a_q <= s3_a_q; s4_b_q <= s3_b_q; s4_c_q <= s3_c_q;
      s4_absc_q <= absc_d;
      s4_edge_q <= edge_d;
      s4_dx_q <= s3_dx_q; s4_dy_q <= s3_dy_q;
      s4_z0_q <= s3_z0_q; s4_mz_q <= s3_mz_q;

      s5_cl_q <= $signed({1'b0, s4_c_q[L-1:0]}) * z0e;
      s5_ch_q <= $signed(s4_c_q[PW-1:L]) * z0e;
      s5_al_q <= $signed({1'b0, s4_a_q[L-1:0]}) * s4_dx_q;
      s5_ah_q <= $signed(s4_a_q[PW-1:L]) * s4_dx_q;
      s5_bl_q <= $signed({1'b0, s4_b_q[L-1:0]}) * s4_dy_q;
      s5_bh_q <= $signed(s4_b_q[PW-1:L]) * s4_dy_q;
      s5_absc_q <= s4_absc_q;
      s5_edge_q <= s4_edge_q;
      s5_cneg_q <= s4_c_q[PW-1];
      s5_mz_q <= s4_mz_q;

      s6_tc_q <= (chx <<< L) + clx;
      s6_ta_q <= (ahx <<< L) + alx;
      s6_tb_q <= (bhx <<< L) + blx;
      s6_absc_q <= s5_absc_q; s6_edge_q <= s5_edge_q;
      s6_cneg_q <= s5_cneg_q; s6_mz_q <= s5_mz_q;

      s7_num_q <= s6_tc_q - s6_ta_q - s6_tb_q;
      s7_absc_q <= s6_absc_q; s7_edge_q <= s6_edge_q;
      s7_cneg_q <= s6_cneg_q; s7_mz_q <= s6_mz_q;

      s8_absn_q <= s7_num_q[NW-1] ? NW'(-s7_num_q) : NW'(s7_num_q);
      s8_neg_q  <= s7_num_q[NW-1] ^ s7_cneg_q;
      s8_absc_q <= s7_absc_q; s8_edge_q <= s7_edge_q; s8_mz_q <= s7_mz_q;

      s9_n2_q <= {s8_absn_q, 1'b0} + RW'(s8_absc_q);
      s9_d2_q <= {s8_absc_q, 1'b0};
      s9_edge_q <= s8_edge_q; s9_neg_q <= s8_neg_q; s9_mz_q <= s8_mz_q;

      s10_n2_q <= s9_n2_q;
      s10_d2_q <= s9_d2_q;
      s10_flags_q.edge_on <= s9_edge_q;
      s10_flags_q.neg     <= s9_neg_q;
      s10_flags_q.ovf     <= s9_n2_q >= (RW'(s9_d2_q) << QB);
      s10_mz_q <= s9_mz_q;
    end
  end

  assign valid_o = v_q[9];
  assign n2_o    = s10_n2_q;
  assign d2_o    = s10_d2_q;
  assign minz_o  = s10_mz_q;
  assign flags_o = s10_flags_q;

endmodule

`default_nettype wire

/* src/tpd_div.sv */
// Restoring divider pipeline, one quotient bit per stage, most significant first.
// Depends on tpd_pkg.
`default_nettype none

module tpd_div #(
  parameter int CoordWidth = tpd_pkg::COORD_WIDTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire [3*(CoordWidth+1)+3:0]   n2_i,
  input  wire [2*(CoordWidth+1)+1:0]   d2_i,
  input  wire [CoordWidth-1:0]         minz_i,
  input  tpd_pkg::tpd_flags_t          flags_i,
  output logic                         valid_o,
  output logic [CoordWidth:0]          quot_o,
  output logic [CoordWidth-1:0]        minz_o,
  output tpd_pkg::tpd_flags_t          flags_o
);
  import tpd_pkg::*;

  localparam int W  = CoordWidth;
  localparam int RW = 3 * (W + 1) + 4;
  localparam int DW = 2 * (W + 1) + 2;
  localparam int QB = W + 1;

  // Entry i holds the state after stage i.
  logic [QB-1:0]       v_q;
  logic [RW-1:0]       rem_q   [QB];
  logic [QB-1:0]       quot_q  [QB];
  logic [DW-1:0]       d2_q    [QB];
  logic [W-1:0]        mz_q    [QB];
  tpd_flags_t          flags_q [QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QB-2:0], valid_i};
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int K = QB - 1 - i;
    logic [RW-1:0] rem_in;
    logic [QB-1:0] quot_in;
    logic [DW-1:0] d2_in;
    logic [W-1:0]  mz_in;
    tpd_flags_t    flags_in;
    logic [RW-1:0] sh;
    logic          take;

    if (i == 0) begin : g_head
      assign rem_in   = n2_i;
      assign quot_in  = '0;
      assign d2_in    = d2_i;
      assign mz_in    = minz_i;
      assign flags_in = flags_i;
    end else begin : g_tail
      assign rem_in   = rem_q[i-1];
      assign quot_in  = quot_q[i-1];
      assign d2_in    = d2_q[i-1];
      assign mz_in    = mz_q[i-1];
      assign flags_in = flags_q[i-1];
    end

    assign sh   = RW'(d2_in) << K;
    assign take = rem_in >= sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]   <= take ? rem_in - sh : rem_in;
        quot_q[i]  <= quot_in | (QB'(take) << K);
        d2_q[i]    <= d2_in;
        mz_q[i]    <= mz_in;
        flags_q[i] <= flags_in;
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign quot_o  = quot_q[QB-1];
  assign minz_o  = mz_q[QB-1];
  assign flags_o = flags_q[QB-1];

endmodule

`default_nettype wire
